// ===== hdl/rgb_to_hsl_converter_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef RGB_TO_HSL_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define RTH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define RTH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define RTH_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rth_pkg.sv =====
`default_nettype none
package rth_pkg;

  localparam int COMP_BITS = 8;
  localparam int FRAC_BITS = 12;

  localparam int SUM_W  = COMP_BITS + 1;
  localparam int HDIV_W = COMP_BITS + 3;

  typedef logic [COMP_BITS-1:0] comp_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [HDIV_W-1:0]    hdiv_t;
  typedef logic [FRAC_BITS-1:0] frac_t;

  localparam int    COMP_MAX_I = (1 << COMP_BITS) - 1;
  localparam sum_t  COMP_MAX   = sum_t'(COMP_MAX_I);
  localparam sum_t  SUM_MAX    = sum_t'(2 * COMP_MAX_I);
  localparam frac_t FRAC_MAX   = frac_t'((1 << FRAC_BITS) - 1);

  // Word moving down the divider pipeline.
  typedef struct packed {
    logic  grey;
    logic  sat_full;
    sum_t  srem;
    sum_t  sden;
    frac_t squo;
    hdiv_t hrem;
    hdiv_t hdiv;
    frac_t hquo;
    sum_t  lsum;
  } work_t;

endpackage
`default_nettype wire

// ===== hdl/rth_ifs.sv =====
`default_nettype none
interface rth_in_if;
  import rth_pkg::*;
  logic  valid;
  logic  ready;
  comp_t red;
  comp_t green;
  comp_t blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_out_if;
  import rth_pkg::*;
  logic  valid;
  logic  ready;
  frac_t hue_turn;
  frac_t saturation;
  sum_t  lightness_sum;
  modport source (output valid, output hue_turn, output saturation,
                  output lightness_sum, input ready);
  modport sink (input valid, input hue_turn, input saturation,
                input lightness_sum, output ready);
endinterface
`default_nettype wire

// ===== hdl/rth_prep.sv =====
`default_nettype none
module rth_prep (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire rth_pkg::comp_t r,
  input  wire rth_pkg::comp_t g,
  input  wire rth_pkg::comp_t b,
  output logic                out_valid,
  output rth_pkg::work_t      out_work
);
  import rth_pkg::*;

  logic  red_max;
  logic  green_max;
  comp_t hi;
  comp_t lo;
  comp_t delta;
  sum_t  sum;
  sum_t  den;
  hdiv_t d6;
  hdiv_t num;
  work_t work_next;

  always_comb begin
    red_max   = (r >= g) && (r >= b);
    green_max = !red_max && (g >= b);
    hi = red_max ? r : (green_max ? g : b);
    if (r <= g && r <= b) begin
      lo = r;
    end else if (g <= b) begin
      lo = g;
    end else begin
      lo = b;
    end
    delta = hi - lo;
    sum   = sum_t'(hi) + sum_t'(lo);
    den   = (sum <= COMP_MAX) ? sum : SUM_MAX - sum;
    d6    = (hdiv_t'(delta) << 2) + (hdiv_t'(delta) << 1);
    // Sextant numerator, wrapped into [0, 6*delta)
    if (red_max) begin
      num = (g >= b) ? hdiv_t'(g - b) : d6 - hdiv_t'(b - g);
    end else if (green_max) begin
      num = (hdiv_t'(delta) << 1) + hdiv_t'(b) - hdiv_t'(r);
    end else begin
      num = (hdiv_t'(delta) << 2) + hdiv_t'(r) - hdiv_t'(g);
    end

    work_next.grey     = (delta == '0);
    work_next.sat_full = (sum_t'(delta) == den);
    work_next.srem     = sum_t'(delta);
    work_next.sden     = den;
    work_next.squo     = '0;
    work_next.hrem     = num;
    work_next.hdiv     = d6;
    work_next.hquo     = '0;
    work_next.lsum     = sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_work <= work_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rth_div_stage.sv =====
`default_nettype none
module rth_div_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire rth_pkg::work_t in_work,
  output logic                out_valid,
  output rth_pkg::work_t      out_work
);
  import rth_pkg::*;

  logic [SUM_W:0]  srem2;
  logic [SUM_W:0]  sdiff;
  logic            sge;
  logic [HDIV_W:0] hrem2;
  logic [HDIV_W:0] hdiff;
  logic            hge;
  work_t           work_next;

  // One restoring quotient bit for each divider
  always_comb begin
    srem2 = {in_work.srem, 1'b0};
    sge   = srem2 >= {1'b0, in_work.sden};
    sdiff = srem2 - {1'b0, in_work.sden};
    hrem2 = {in_work.hrem, 1'b0};
    hge   = hrem2 >= {1'b0, in_work.hdiv};
    hdiff = hrem2 - {1'b0, in_work.hdiv};

    work_next      = in_work;
    work_next.srem = sge ? sdiff[SUM_W-1:0] : srem2[SUM_W-1:0];
    work_next.squo = {in_work.squo[FRAC_BITS-2:0], sge};
    work_next.hrem = hge ? hdiff[HDIV_W-1:0] : hrem2[HDIV_W-1:0];
    work_next.hquo = {in_work.hquo[FRAC_BITS-2:0], hge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_work <= work_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rgb_to_hsl_converter_unit.sv =====
// RGB to HSL pixel converter.
// Input channel pix carries one pixel word of red, green and blue components.
// Output channel hsl carries hue_turn (1/4096 of a turn), saturation
// (1/4096, clamped at 4095) and lightness_sum (max + min, over 510).
// Both channels use valid/ready; a word moves when both are high.
// The accepting edge loads a stage that finds max, min, sum and the two
// divisor/numerator pairs, then twelve stages each produce one quotient bit
// of the saturation and hue dividers.
// Throughput is one pixel per cycle; a new pixel is taken every cycle
// while the output is empty or being taken.
// When the receiver holds ready low with a valid word, the whole pipeline
// freezes and pix.ready drops; nothing is lost or repeated.
// Synchronous reset empties every stage; hsl.valid is low afterwards.
`default_nettype none
module rgb_to_hsl_converter_unit (
  input wire logic  clk,
  input wire logic  rst,
  rth_in_if.sink    pix,
  rth_out_if.source hsl
);
  import rth_pkg::*;

  logic  en;
  logic  stage_valid [0:FRAC_BITS];
  work_t stage_work  [0:FRAC_BITS];
  work_t last;

  // Advance the pipeline unless a finished word is waiting
  assign en        = !hsl.valid || hsl.ready;
  assign pix.ready = en;

  rth_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pix.valid),
    .r         (pix.red),
    .g         (pix.green),
    .b         (pix.blue),
    .out_valid (stage_valid[0]),
    .out_work  (stage_work[0])
  );

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    rth_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stage_valid[i]),
      .in_work   (stage_work[i]),
      .out_valid (stage_valid[i+1]),
      .out_work  (stage_work[i+1])
    );
  end

  assign last          = stage_work[FRAC_BITS];
  assign hsl.valid     = stage_valid[FRAC_BITS];
  assign hsl.lightness_sum = last.lsum;
  assign hsl.hue_turn  = last.grey ? '0 : last.hquo;
  // Saturation is clamped to FRAC_MAX when delta equals the divisor
  assign hsl.saturation = last.grey ? '0 : (last.sat_full ? FRAC_MAX : last.squo);

endmodule
`default_nettype wire

// ===== hdl/rth_checker.sv =====
`default_nettype none
`include "rgb_to_hsl_converter_unit_macros.svh"
module rth_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire rth_pkg::frac_t hue,
  input wire rth_pkg::frac_t sat,
  input wire rth_pkg::sum_t  lsum
);
  import rth_pkg::*;

  `RTH_ASSERT_NXT_ALL(a_reset_empty, clk, rst, !out_valid, "output valid after reset")
  `RTH_ASSERT_IMP(a_ready_free, clk, rst, !out_valid || out_ready, in_ready, "input stalled while output free")
  `RTH_ASSERT_IMP(a_grey_hue, clk, rst, out_valid && (sat == '0), hue == '0, "hue set on a grey pixel")
  `RTH_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(hue) && $stable(sat) && $stable(lsum), "stalled word changed")

endmodule

bind rgb_to_hsl_converter_unit rth_checker u_rth_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix.ready),
  .out_valid (hsl.valid),
  .out_ready (hsl.ready),
  .hue       (hsl.hue_turn),
  .sat       (hsl.saturation),
  .lsum      (hsl.lightness_sum)
);
`default_nettype wire
